FILE: rtl/core/fvpd_pkg.sv
// shared constants and the sine evaluation used to build the trig tables
package fvpd_pkg;

  // widths of the fixed fields
  localparam int SUPPLY_W = 16;
  localparam int TORQUE_W = 16;
  localparam int ANGLE_W  = 16;
  localparam int DUTY_W   = 8;
  localparam int TRIG_W   = 16;

  // defaults for the top-level parameters
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int DUTY_MAX_DEF         = 255;

  // supply register reset: 12 V in 1/256 V
  localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 16'd3072;

  // register index decoded from paddr[2]
  localparam logic REG_IDX_SUPPLY = 1'b0;

  // fixed-point constants, Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [30:0] SQRT3_Q30   = 31'd1859775393;

  // Q1.15 sine of a 32-bit turn fraction: odd series to x^15 on the first quadrant
  function automatic logic signed [TRIG_W-1:0] sine_at(input logic [31:0] p);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    quad = p[31:30];
    r    = {34'd0, p[29:0]};
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x   = (r * HALF_PI_Q30) >> 30;
    x2  = (x * x) >> 30;
    t   = x;
    sum = signed'(x);
    for (int k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - signed'(t);
      end else begin
        sum = sum + signed'(t);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    if (quad[1]) begin
      v = -v;
    end
    return v[TRIG_W-1:0];
  endfunction

endpackage

FILE: rtl/core/fvpd_trig_rom.sv
// sine and cosine lookup rom with registered read
module fvpd_trig_rom
  import fvpd_pkg::*;
#(
  parameter int Depth = SINE_TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic [$clog2(Depth)-1:0]   idx_i,
  output logic signed [TRIG_W-1:0]   sin_o,
  output logic signed [TRIG_W-1:0]   cos_o
);

  typedef logic signed [TRIG_W-1:0] tab_t [Depth];

  // one entry per table step, phase offset selects sine or cosine
  function automatic tab_t build_tab(input logic [31:0] offs);
    tab_t        tab;
    logic [63:0] ph;
    for (int i = 0; i < Depth; i++) begin
      ph     = (64'(i) << 32) / Depth;
      tab[i] = sine_at(ph[31:0] + offs);
    end
    return tab;
  endfunction

  localparam tab_t SinTab = build_tab(32'h0000_0000);
  localparam tab_t CosTab = build_tab(32'h4000_0000);

  logic signed [TRIG_W-1:0] sin_q;
  logic signed [TRIG_W-1:0] cos_q;

  // registered read of both tables
  always_ff @(posedge clk_i) begin
    sin_q <= SinTab[idx_i];
    cos_q <= CosTab[idx_i];
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

FILE: rtl/core/fvpd_div_lane.sv
// pipelined restoring divider, one quotient bit per stage
module fvpd_div_lane
  import fvpd_pkg::*;
#(
  parameter int QuoW = 8,
  parameter int NumW = SUPPLY_W + QuoW
) (
  input  logic                clk_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [SUPPLY_W-1:0] den_i,
  output logic [QuoW-1:0]     quo_o
);

  logic [NumW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int ShiftAmt = QuoW - 1 - i;

    logic [NumW-1:0] rem_in;
    logic [QuoW-1:0] quo_in;
    logic [NumW-1:0] shd;
    logic [NumW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign shd = NumW'(den_i) << ShiftAmt;

    always_comb begin
      ge    = (rem_in >= shd);
      rem_d = ge ? (rem_in - shd) : rem_in;
      quo_d = {quo_in[QuoW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      quo_q[i] <= quo_d;
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

FILE: rtl/core/foc_voltage_to_phase_duty_core.sv
// q-axis voltage to three phase pwm duties: inverse park, inverse clarke, duty scaling
//
//  channel   direction  signals                                   transaction
//  command   in         start, busy, torque_voltage_i,            start && !busy
//                       electrical_angle_i
//  result    out        done_o, duty_a_o, duty_b_o, duty_c_o      done_o, one cycle
//  config    in/out     psel, penable, pwrite, paddr, pwdata,     psel && penable
//                       prdata, pready                            && pwrite
//
//  one command per cycle; busy is always low
//  the divider retires one quotient bit per stage and feeds the output register
//  reset clears the valid chain and loads the supply register with 3072
//  results leave on a one-cycle strobe; the receiver cannot hold them off
module foc_voltage_to_phase_duty_core
  import fvpd_pkg::*;
#(
  parameter int SineTableDepth = SINE_TABLE_DEPTH_DEF,
  parameter int DutyMax        = DUTY_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command
  input  logic                       start,
  output logic                       busy,
  input  logic signed [TORQUE_W-1:0] torque_voltage_i,
  input  logic [ANGLE_W-1:0]         electrical_angle_i,
  // result
  output logic                       done_o,
  output logic [DUTY_W-1:0]          duty_a_o,
  output logic [DUTY_W-1:0]          duty_b_o,
  output logic [DUTY_W-1:0]          duty_c_o,
  // config
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IdxW   = $clog2(SineTableDepth);
  localparam int DepthW = $clog2(SineTableDepth + 1);
  localparam int AngPW  = ANGLE_W + DepthW;
  localparam int QuoW   = $clog2(DutyMax + 1);
  localparam int NumW   = SUPPLY_W + QuoW;
  localparam int UW     = SUPPLY_W + 17;
  localparam int PW     = UW + QuoW;
  localparam int Lat    = 9 + QuoW;

  // ---------------- config register ----------------
  logic [SUPPLY_W-1:0] supply_q;
  logic [SUPPLY_W-1:0] supply_d;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_SUPPLY);

  always_comb begin
    supply_d = supply_q;
    if (cfg_wr) begin
      supply_d = pwdata[SUPPLY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RESET;
    end else begin
      supply_q <= supply_d;
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_SUPPLY) begin
      prdata = {{(32-SUPPLY_W){1'b0}}, supply_q};
    end
  end

  // ---------------- handshake and valid chain ----------------
  logic           accept;
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] vld_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vld_d  = {vld_q[Lat-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[Lat-1];

  // ---------------- stage 1: demand clamp, table index ----------------
  logic signed [17:0] tv2;
  logic signed [17:0] sup_s;
  logic signed [17:0] uq2_w;
  logic [AngPW-1:0]   ang_prod;
  logic signed [16:0] s1_uq2_d, s1_uq2_q;
  logic [IdxW-1:0]    s1_idx_d, s1_idx_q;

  always_comb begin
    tv2   = signed'({torque_voltage_i[TORQUE_W-1], torque_voltage_i, 1'b0});
    sup_s = signed'({2'b00, supply_q});
    if (tv2 > sup_s) begin
      uq2_w = sup_s;
    end else if (tv2 < -sup_s) begin
      uq2_w = -sup_s;
    end else begin
      uq2_w = tv2;
    end
    s1_uq2_d = uq2_w[16:0];
    ang_prod = AngPW'(electrical_angle_i) * AngPW'(SineTableDepth);
    s1_idx_d = ang_prod[ANGLE_W +: IdxW];
  end

  // ---------------- stage 2: sine and cosine lookup ----------------
  logic signed [TRIG_W-1:0] sin_w;
  logic signed [TRIG_W-1:0] cos_w;
  logic signed [16:0]       s2_uq2_q;

  fvpd_trig_rom #(
    .Depth (SineTableDepth)
  ) u_trig_rom (
    .clk_i (clk_i),
    .idx_i (s1_idx_q),
    .sin_o (sin_w),
    .cos_o (cos_w)
  );

  // ---------------- stage 3: inverse park ----------------
  logic signed [32:0] s3_alpha_d, s3_alpha_q;
  logic signed [32:0] s3_beta_d, s3_beta_q;

  always_comb begin
    s3_alpha_d = -(33'(s2_uq2_q) * 33'(sin_w));
    s3_beta_d  = 33'(s2_uq2_q) * 33'(cos_w);
  end

  // ---------------- stage 4: beta sign and magnitude ----------------
  logic signed [32:0] beta_mag;
  logic               s4_neg_q;
  logic [30:0]        s4_mag_d, s4_mag_q;
  logic signed [32:0] s4_alpha_q;

  always_comb begin
    beta_mag = s3_beta_q[32] ? -s3_beta_q : s3_beta_q;
    s4_mag_d = beta_mag[30:0];
  end

  // ---------------- stage 5: beta times sqrt(3) ----------------
  logic [61:0]        s5_prod_d, s5_prod_q;
  logic               s5_neg_q;
  logic signed [32:0] s5_alpha_q;

  assign s5_prod_d = 62'(s4_mag_q) * 62'(SQRT3_Q30);

  // ---------------- stage 6: round half away from zero, restore sign ----------------
  logic [61:0]        rnd;
  logic signed [33:0] sb_mag;
  logic signed [33:0] s6_sb_d, s6_sb_q;
  logic signed [32:0] s6_alpha_q;

  always_comb begin
    rnd     = s5_prod_q + 62'h2000_0000;
    sb_mag  = signed'({2'b00, rnd[61:30]});
    s6_sb_d = s5_neg_q ? -sb_mag : sb_mag;
  end

  // ---------------- stage 7: inverse clarke and clamp ----------------
  function automatic logic [UW-1:0] clamp_u(input logic signed [35:0] v,
                                            input logic signed [35:0] f);
    if (v < 0) begin
      return '0;
    end else if (v > f) begin
      return f[UW-1:0];
    end else begin
      return v[UW-1:0];
    end
  endfunction

  logic signed [35:0] a36;
  logic signed [35:0] sb36;
  logic signed [35:0] hs36;
  logic signed [35:0] full36;
  logic [UW-1:0]      s7_u_d [3];
  logic [UW-1:0]      s7_u_q [3];

  always_comb begin
    a36       = 36'(s6_alpha_q);
    sb36      = 36'(s6_sb_q);
    hs36      = signed'(36'({supply_q, 16'b0}));
    full36    = signed'(36'({supply_q, 17'b0}));
    s7_u_d[0] = clamp_u((a36 <<< 1) + hs36, full36);
    s7_u_d[1] = clamp_u(sb36 - a36 + hs36, full36);
    s7_u_d[2] = clamp_u(-a36 - sb36 + hs36, full36);
  end

  // ---------------- stage 8: scale by duty full scale ----------------
  logic [PW-1:0]   scl [3];
  logic [NumW-1:0] s8_num_d [3];
  logic [NumW-1:0] s8_num_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scl[i]      = PW'(s7_u_q[i]) * PW'(DutyMax);
      s8_num_d[i] = scl[i][17 +: NumW];
    end
  end

  // payload registers of stages 1 to 8
  always_ff @(posedge clk_i) begin
    s1_uq2_q   <= s1_uq2_d;
    s1_idx_q   <= s1_idx_d;
    s2_uq2_q   <= s1_uq2_q;
    s3_alpha_q <= s3_alpha_d;
    s3_beta_q  <= s3_beta_d;
    s4_neg_q   <= s3_beta_q[32];
    s4_mag_q   <= s4_mag_d;
    s4_alpha_q <= s3_alpha_q;
    s5_prod_q  <= s5_prod_d;
    s5_neg_q   <= s4_neg_q;
    s5_alpha_q <= s4_alpha_q;
    s6_sb_q    <= s6_sb_d;
    s6_alpha_q <= s5_alpha_q;
    s7_u_q     <= s7_u_d;
    s8_num_q   <= s8_num_d;
  end

  // ---------------- division by the supply, one lane per phase ----------------
  logic [QuoW-1:0]   quo_w [3];
  logic [DUTY_W-1:0] duty_d [3];
  logic [DUTY_W-1:0] duty_q [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    fvpd_div_lane #(
      .QuoW (QuoW),
      .NumW (NumW)
    ) u_div (
      .clk_i (clk_i),
      .num_i (s8_num_q[g]),
      .den_i (supply_q),
      .quo_o (quo_w[g])
    );

    // zero supply forces all duties off
    assign duty_d[g] = (supply_q == '0) ? '0 : quo_w[g][DUTY_W-1:0];
  end

  // output register
  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
  end

  assign duty_a_o = duty_q[0];
  assign duty_b_o = duty_q[1];
  assign duty_c_o = duty_q[2];

`ifndef SYNTHESIS
  localparam logic [DUTY_W-1:0] MidDuty = DUTY_W'(DutyMax / 2);

  // every accepted command yields a result on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Lat done_o)
    else $error("result missing after accepted command");

  // no result without a matching accepted command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Lat))
    else $error("result without matching command");

  // zero demand gives all three phases at mid scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (torque_voltage_i == '0) && (supply_q != '0) |-> ##Lat
      (duty_a_o == MidDuty && duty_b_o == MidDuty && duty_c_o == MidDuty))
    else $error("zero demand did not give mid-scale duties");
`endif

endmodule
